### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on clk, off while rst is high
`define TRAG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked on clk, also checked through reset
`define TRAG_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/trag_pkg.sv
package trag_pkg;

  localparam int OFFSET_W    = 48;
  localparam int SIZE_REG_W  = 13;
  localparam int SHIFT_REG_W = 12;
  localparam int CFG_DATA_W  = 13;

  typedef logic [OFFSET_W-1:0] offset_t;

  typedef struct packed {
    logic load;
    logic advance;
  } axis_ctrl_t;

endpackage

### rtl/tensor_roll_address_generator.sv
// channel  | handshake                | payload
// ---------+--------------------------+------------------------------------------
// in       | in_valid / in_ready      | value_in
// out      | out_valid / out_ready    | value_out, dest_offset, last_of_tensor,
//          |                          | shift_error
// cfg      | cfg_we                   | cfg_index, cfg_data
//
// One item per cycle while in_ready is high; each item appears on out in the cycle after it is accepted.
// Per-axis offset terms are kept up to date incrementally, so the output
// register only sees one MAX_DIMS-way 48-bit add.
// After rst and after every in-range register write, strides are rebuilt by
// shared 48x13 multipliers, one axis per cycle; in_ready stays low meanwhile.
// in_ready also drops while a result waits with out_ready low.
module tensor_roll_address_generator #(
  parameter int MAX_DIMS  = 4,
  parameter int DIM_BITS  = 12,
  parameter int DATA_BITS = 64
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_we,
  input  logic [$clog2(2*MAX_DIMS)-1:0]                 cfg_index,
  input  logic [trag_pkg::CFG_DATA_W-1:0]               cfg_data,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [DATA_BITS-1:0]                          value_in,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [DATA_BITS-1:0]                          value_out,
  output trag_pkg::offset_t                             dest_offset,
  output logic                                          last_of_tensor,
  output logic                                          shift_error
);
  import trag_pkg::*;

  localparam int CFG_IDX_W = $clog2(2*MAX_DIMS);
  localparam int SIZE_W    = DIM_BITS + 1;
  localparam int IDX_W     = ((DIM_BITS > SHIFT_REG_W) ? DIM_BITS : SHIFT_REG_W) + 1;
  localparam int CMP_W     = (SIZE_W > SIZE_REG_W) ? SIZE_W : SIZE_REG_W;
  localparam int STEP_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam logic [CMP_W-1:0] MaxSize = CMP_W'(1) << DIM_BITS;

  logic [SIZE_REG_W-1:0]  size_reg  [MAX_DIMS];
  logic [SHIFT_REG_W-1:0] shift_reg [MAX_DIMS];
  logic [SIZE_W-1:0]      size_eff  [MAX_DIMS];
  logic [IDX_W-1:0]       base_idx  [MAX_DIMS];
  logic [MAX_DIMS-1:0]    bad;
  logic [MAX_DIMS-1:0]    wrap;
  logic [MAX_DIMS-1:0]    carry;
  offset_t                contrib   [MAX_DIMS];
  axis_ctrl_t             axis_ctrl [MAX_DIMS];

  logic                   cfg_hit;
  logic                   busy;
  logic [STEP_W-1:0]      step;
  offset_t                acc;
  logic [OFFSET_W+SIZE_W-1:0] mul_size;
  logic [OFFSET_W+IDX_W-1:0]  mul_base;
  offset_t                prod_size;
  offset_t                prod_base;
  offset_t                dropstep;
  offset_t                offset_sum;
  logic                   accept;

  assign cfg_hit = cfg_we && ({1'b0, cfg_index} < (CFG_IDX_W+1)'(2*MAX_DIMS));

  // configuration registers and derived per-axis values
  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_cfg
    logic [CMP_W-1:0] sreg_ext;
    logic [CMP_W-1:0] eff_ext;
    logic [IDX_W-1:0] shift_ext;
    logic [IDX_W-1:0] size_ext;

    always_ff @(posedge clk) begin
      if (rst) begin
        size_reg[i]  <= SIZE_REG_W'(1);
        shift_reg[i] <= '0;
      end else if (cfg_we) begin
        if ({1'b0, cfg_index} == (CFG_IDX_W+1)'(i)) begin
          size_reg[i] <= cfg_data;
        end
        if ({1'b0, cfg_index} == (CFG_IDX_W+1)'(MAX_DIMS + i)) begin
          shift_reg[i] <= cfg_data[SHIFT_REG_W-1:0];
        end
      end
    end

    assign sreg_ext    = CMP_W'(size_reg[i]);
    assign eff_ext     = (sreg_ext == '0) ? CMP_W'(1)
                       : ((sreg_ext > MaxSize) ? MaxSize : sreg_ext);
    assign size_eff[i] = SIZE_W'(eff_ext);
    assign shift_ext   = IDX_W'(shift_reg[i]);
    assign size_ext    = IDX_W'(size_eff[i]);
    assign bad[i]      = (shift_ext >= size_ext);
    assign base_idx[i] = bad[i] ? (shift_ext - size_ext) : shift_ext;
  end

  // stride rebuild, innermost axis first
  assign mul_size  = acc * size_eff[step];
  assign mul_base  = acc * base_idx[step];
  assign prod_size = mul_size[OFFSET_W-1:0];
  assign prod_base = mul_base[OFFSET_W-1:0];
  assign dropstep  = acc - prod_size;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      busy <= 1'b1;
      step <= STEP_W'(MAX_DIMS - 1);
      acc  <= OFFSET_W'(1);
    end else if (busy) begin
      acc <= prod_size;
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - STEP_W'(1);
      end
    end
  end

  // odometer carries
  assign in_ready = !busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    carry[MAX_DIMS-1] = 1'b1;
    for (int i = MAX_DIMS - 2; i >= 0; i--) begin
      carry[i] = carry[i+1] & wrap[i+1];
    end
  end

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_axis
    assign axis_ctrl[i].load    = busy && (step == STEP_W'(i));
    assign axis_ctrl[i].advance = accept && carry[i];

    trag_axis #(
      .DIM_BITS(DIM_BITS)
    ) u_axis (
      .clk          (clk),
      .ctrl         (axis_ctrl[i]),
      .size_eff     (size_eff[i]),
      .bad          (bad[i]),
      .base_idx     (base_idx[i]),
      .stride       (acc),
      .base_contrib (prod_base),
      .dropstep     (dropstep),
      .contrib      (contrib[i]),
      .wrap         (wrap[i])
    );
  end

  always_comb begin
    offset_sum = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      offset_sum = offset_sum + contrib[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_out      <= value_in;
      dest_offset    <= offset_sum;
      last_of_tensor <= carry[0] & wrap[0];
      shift_error    <= |bad;
    end
  end

endmodule

### rtl/trag_axis.sv
module trag_axis #(
  parameter int DIM_BITS = 12
) (
  input  logic                                          clk,
  input  trag_pkg::axis_ctrl_t                          ctrl,
  input  logic [DIM_BITS:0]                             size_eff,
  input  logic                                          bad,
  input  logic [((DIM_BITS > trag_pkg::SHIFT_REG_W) ? DIM_BITS
                 : trag_pkg::SHIFT_REG_W):0]            base_idx,
  input  trag_pkg::offset_t                             stride,
  input  trag_pkg::offset_t                             base_contrib,
  input  trag_pkg::offset_t                             dropstep,
  output trag_pkg::offset_t                             contrib,
  output logic                                          wrap
);
  import trag_pkg::*;

  localparam int SIZE_W = DIM_BITS + 1;
  localparam int IDX_W  = ((DIM_BITS > SHIFT_REG_W) ? DIM_BITS : SHIFT_REG_W) + 1;

  logic [DIM_BITS-1:0] pos;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    base_idx_r;
  offset_t             stride_r;
  offset_t             drop_r;
  offset_t             base_c_r;
  logic                at_top;

  assign wrap   = ({1'b0, pos} == (size_eff - SIZE_W'(1)));
  assign at_top = !bad && (idx == (IDX_W'(size_eff) - IDX_W'(1)));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pos        <= '0;
      idx        <= base_idx;
      contrib    <= base_contrib;
      base_idx_r <= base_idx;
      base_c_r   <= base_contrib;
      stride_r   <= stride;
      drop_r     <= dropstep;
    end else if (ctrl.advance) begin
      if (wrap) begin
        pos     <= '0;
        idx     <= base_idx_r;
        contrib <= base_c_r;
      end else begin
        pos <= pos + DIM_BITS'(1);
        if (at_top) begin
          idx     <= '0;
          contrib <= contrib + drop_r;
        end else begin
          idx     <= idx + IDX_W'(1);
          contrib <= contrib + stride_r;
        end
      end
    end
  end

endmodule

### rtl/trag_checker.sv
`include "assert_macros.svh"

module trag_checker #(
  parameter int MAX_DIMS  = 4,
  parameter int DATA_BITS = 64
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_we,
  input logic [$clog2(2*MAX_DIMS)-1:0]       cfg_index,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [DATA_BITS-1:0]                value_out,
  input trag_pkg::offset_t                   dest_offset
);
  import trag_pkg::*;

  localparam int CFG_IDX_W = $clog2(2*MAX_DIMS);

  logic cfg_hit;

  assign cfg_hit = cfg_we && ({1'b0, cfg_index} < (CFG_IDX_W+1)'(2*MAX_DIMS));

  `TRAG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(dest_offset) && $stable(value_out), "stalled result changed")
  `TRAG_ASSERT(a_accept_fills, in_valid && in_ready |=> out_valid, "accepted item gave no result")
  `TRAG_ASSERT(a_cfg_blocks, cfg_hit |=> !in_ready, "input taken during stride rebuild")
  `TRAG_ASSERT_RST(a_rst_blocks, rst |=> !in_ready && !out_valid, "block not held after reset")

endmodule

bind tensor_roll_address_generator trag_checker #(
  .MAX_DIMS  (MAX_DIMS),
  .DATA_BITS (DATA_BITS)
) u_trag_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_we      (cfg_we),
  .cfg_index   (cfg_index),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .value_out   (value_out),
  .dest_offset (dest_offset)
);
